>>> hdl/cil_pkg.sv
package cil_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int ID_W      = 31;
  localparam int IDX_W     = 4;
  localparam int OP_W      = 3;
  localparam int ST_W      = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 3'd0,
    OP_ADD   = 3'd1,
    OP_DEL   = 3'd2,
    OP_READ  = 3'd3,
    OP_FLUSH = 3'd4
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_PRESENT   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_EDIT,
    S_SCAN,
    S_TAIL
  } state_e;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_EDIT,
    OUT_PEND,
    OUT_EMPTY
  } out_sel_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic     capture;
    logic     compare;
    logic     edit;
    logic     scan_adv;
    out_sel_e out_sel;
    logic     out_last;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic is_scan;
    logic take;
    logic pend_v;
    logic cur_last;
  } stat_t;

endpackage

>>> hdl/compacting_id_list_unit.sv
// channel   | dir | tdata (low bit up)                        | tuser / tlast
// ----------+-----+-------------------------------------------+----------------------------
// s_axis    | in  | slot_index[3:0], item_id[34:4], pad 39:35 | tuser: opcode[2:0]
// m_axis    | out | out_slot[3:0], slot_value[34:4], pad      | tuser: status[1:0],
//           |     |                                           | entry_valid[2]; tlast: last
//
// load, add and delete: accept, a registered compare of all slots, then the edit
// read and flush: accept, compare, a scan in which the cursor visits one slot per cycle unless
// a hit waits on m_axis, then a tail; one qualifying entry is held back so the final one can carry tlast
// a new request is accepted while the last result still sits in the output register
// reset clears all slots and changed flags at once; no clearing pass
// a stalled m_axis holds the edit or the scan cursor until the output register frees up
module compacting_id_list_unit
  import cil_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // slot_index, item_id
  input  logic [2:0]  s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // out_slot, slot_value
  output logic [2:0]  m_axis_tuser,  // status, entry_valid
  output logic        m_axis_tlast
);

  cmd_t             cmd;
  stat_t            stat;
  logic [ST_W-1:0]  status;
  logic [IDX_W-1:0] out_slot;
  logic [ID_W-1:0]  slot_value;
  logic             entry_valid;

  cil_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cil_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .opcode_i      (s_axis_tuser),
    .slot_index_i  (s_axis_tdata[3:0]),
    .item_id_i     (s_axis_tdata[34:4]),
    .status_o      (status),
    .out_slot_o    (out_slot),
    .slot_value_o  (slot_value),
    .entry_valid_o (entry_valid),
    .last_o        (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b0, slot_value, out_slot};
  assign m_axis_tuser = {entry_valid, status};

endmodule

>>> hdl/cil_datapath.sv
module cil_datapath
  import cil_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output stat_t            stat_o,
  input  logic [OP_W-1:0]  opcode_i,
  input  logic [IDX_W-1:0] slot_index_i,
  input  logic [ID_W-1:0]  item_id_i,
  output logic [ST_W-1:0]  status_o,
  output logic [IDX_W-1:0] out_slot_o,
  output logic [ID_W-1:0]  slot_value_o,
  output logic             entry_valid_o,
  output logic             last_o
);

  localparam int IW = $clog2(SLOTS);

  logic [ID_W-1:0]  slot_q [SLOTS];
  logic [ID_W-1:0]  slot_d [SLOTS];
  logic [ID_W-1:0]  nxt    [SLOTS];
  logic [SLOTS-1:0] flag_q, flag_d;

  logic [OP_W-1:0]  op_q;
  logic [IDX_W-1:0] idx_q;
  logic [ID_W-1:0]  id_q;

  logic [SLOTS-1:0] eq_q, emp_q, eq_d, emp_d;

  logic [IW-1:0]    cnt_q;
  logic             pend_v_q;
  logic [IW-1:0]    pend_slot_q;
  logic [ID_W-1:0]  pend_val_q;
  logic [IW+IDX_W-1:0] pend_wide;

  logic [ST_W-1:0]  out_status_q;
  logic [IDX_W-1:0] out_slot_q;
  logic [ID_W-1:0]  out_value_q;
  logic             out_evalid_q;
  logic             out_last_q;

  logic [SLOTS-1:0] cand, asel, dsel, ge, emp_ge, ssel, below, shift_m, load_m;
  logic             add_present, add_full;
  status_e          edit_status;
  logic [ID_W-1:0]  cur_val;
  logic             cur_flag, take, is_flush;

  // parallel compare against every slot
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      eq_d[i]  = (slot_q[i] == id_q);
      emp_d[i] = (slot_q[i] == '0);
    end
  end

  // successor of each slot, used by the delete shift
  always_comb begin
    for (int i = 0; i < SLOTS - 1; i++) begin
      nxt[i] = slot_q[i+1];
    end
    nxt[SLOTS-1] = '0;
  end

  always_comb begin
    cand        = eq_q | emp_q;
    asel        = cand & (~cand + SLOTS'(1));
    add_present = |(asel & eq_q);
    add_full    = (cand == '0);
    dsel        = eq_q & (~eq_q + SLOTS'(1));
    ge          = ~(dsel - SLOTS'(1));
    emp_ge      = emp_q & ge;
    ssel        = emp_ge & (~emp_ge + SLOTS'(1));
    // shift runs from the hit up to, not including, the first empty slot
    below       = ssel - SLOTS'(1);
    shift_m     = ge & below;
    for (int i = 0; i < SLOTS; i++) begin
      load_m[i] = (i < (2 ** IDX_W)) && (idx_q == IDX_W'(i));
    end
    case (op_q)
      OP_ADD: begin
        if (add_full) begin
          edit_status = ST_FULL;
        end else if (add_present) begin
          edit_status = ST_PRESENT;
        end else begin
          edit_status = ST_OK;
        end
      end
      OP_DEL: begin
        edit_status = (eq_q == '0) ? ST_NOT_FOUND : ST_OK;
      end
      default: begin
        edit_status = ST_OK;
      end
    endcase
  end

  assign cur_val  = slot_q[cnt_q];
  assign cur_flag = flag_q[cnt_q];
  assign is_flush = (op_q == OP_FLUSH);
  assign take     = is_flush ? cur_flag : (cur_val != '0);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_d[i] = slot_q[i];
    end
    flag_d = flag_q;
    if (cmd_i.edit) begin
      case (op_q)
        OP_LOAD: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (load_m[i]) begin
              slot_d[i] = id_q;
              flag_d[i] = 1'b0;
            end
          end
        end
        OP_ADD: begin
          if (!add_full && !add_present) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (asel[i]) begin
                slot_d[i] = id_q;
                flag_d[i] = 1'b1;
              end
            end
          end
        end
        OP_DEL: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (shift_m[i]) begin
              slot_d[i] = nxt[i];
              flag_d[i] = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.scan_adv && take && is_flush) begin
      flag_d[cnt_q] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_q[i] <= '0;
      end
      flag_q   <= '0;
      pend_v_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_q[i] <= slot_d[i];
      end
      flag_q <= flag_d;
      if (cmd_i.compare) begin
        cnt_q    <= '0;
        pend_v_q <= 1'b0;
      end else if (cmd_i.scan_adv) begin
        cnt_q <= cnt_q + IW'(1);
        if (take) begin
          pend_v_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= opcode_i;
      idx_q <= slot_index_i;
      id_q  <= item_id_i;
    end
    if (cmd_i.compare) begin
      eq_q  <= eq_d;
      emp_q <= emp_d;
    end
    if (cmd_i.scan_adv && take) begin
      pend_slot_q <= cnt_q;
      pend_val_q  <= cur_val;
    end
  end

  assign pend_wide = (IW+IDX_W)'(pend_slot_q);

  // output register
  always_ff @(posedge clk_i) begin
    case (cmd_i.out_sel)
      OUT_EDIT: begin
        out_status_q <= edit_status;
        out_slot_q   <= '0;
        out_value_q  <= '0;
        out_evalid_q <= 1'b0;
        out_last_q   <= 1'b1;
      end
      OUT_PEND: begin
        out_status_q <= ST_OK;
        out_slot_q   <= pend_wide[IDX_W-1:0];
        out_value_q  <= pend_val_q;
        out_evalid_q <= 1'b1;
        out_last_q   <= cmd_i.out_last;
      end
      OUT_EMPTY: begin
        out_status_q <= ST_OK;
        out_slot_q   <= '0;
        out_value_q  <= '0;
        out_evalid_q <= 1'b0;
        out_last_q   <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign status_o      = out_status_q;
  assign out_slot_o    = out_slot_q;
  assign slot_value_o  = out_value_q;
  assign entry_valid_o = out_evalid_q;
  assign last_o        = out_last_q;

  assign stat_o.is_scan  = (op_q == OP_READ) || is_flush;
  assign stat_o.take     = take;
  assign stat_o.pend_v   = pend_v_q;
  assign stat_o.cur_last = (cnt_q == IW'(SLOTS - 1));

  a_add_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.edit |-> $onehot0(asel))
    else $error("add selects more than one slot");

  a_del_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.edit |-> ($onehot0(dsel) && $onehot0(ssel)))
    else $error("delete selects more than one start or stop slot");

  a_cursor_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.scan_adv && !cmd_i.compare) |=> (cnt_q == $past(cnt_q) + IW'(1)))
    else $error("scan cursor did not advance by one");

endmodule

>>> hdl/cil_ctrl.sv
module cil_ctrl
  import cil_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  logic  out_ready_i,
  output logic  out_valid_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o.capture  = 1'b0;
    cmd_o.compare  = 1'b0;
    cmd_o.edit     = 1'b0;
    cmd_o.scan_adv = 1'b0;
    cmd_o.out_sel  = OUT_NONE;
    cmd_o.out_last = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CMP;
        end
      end
      S_CMP: begin
        cmd_o.compare = 1'b1;
        state_d       = stat_i.is_scan ? S_SCAN : S_EDIT;
      end
      S_EDIT: begin
        if (out_free) begin
          cmd_o.edit     = 1'b1;
          cmd_o.out_sel  = OUT_EDIT;
          cmd_o.out_last = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_SCAN: begin
        // a hit with an entry still pending has to push that entry out first
        if (!(stat_i.take && stat_i.pend_v && !out_free)) begin
          cmd_o.scan_adv = 1'b1;
          if (stat_i.take && stat_i.pend_v) begin
            cmd_o.out_sel = OUT_PEND;
          end
          if (stat_i.cur_last) begin
            state_d = S_TAIL;
          end
        end
      end
      S_TAIL: begin
        if (out_free) begin
          cmd_o.out_sel  = stat_i.pend_v ? OUT_PEND : OUT_EMPTY;
          cmd_o.out_last = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_sel != OUT_NONE) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_sel != OUT_NONE) |-> out_free)
    else $error("output register overwritten while holding a result");

  a_last_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cmd_o.out_sel != OUT_NONE) && cmd_o.out_last) |=> (state_q == S_IDLE))
    else $error("final result not followed by idle");

  a_scan_tail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.scan_adv && stat_i.cur_last) |=> (state_q == S_TAIL))
    else $error("scan did not end after the last slot");

endmodule
